// ===== rtl/spmq_pkg.sv =====
package spmq_pkg;

   localparam int QUEUE_ID_W = 2;
   localparam int MAX_QUEUES = 4;
   localparam int COUNT_W    = 7;
   localparam int PAYLOAD_W  = 32;
   localparam int SIZE_W     = 16;
   localparam int STATUS_W   = 2;

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_GET = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd3;

   localparam logic [COUNT_W-1:0] LIMIT_RESET = 7'd64;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

// ===== rtl/spmq_ctrl.sv =====
module spmq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output spmq_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   assign req_ready   = (state_ff == ST_IDLE);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (cmd.commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/spmq_datapath.sv =====
module spmq_datapath #(
   parameter int POOL_SIZE  = 64,
   parameter int NUM_QUEUES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spmq_pkg::cmd_type                   cmd,
   input  logic                                req_operation,
   input  logic [spmq_pkg::QUEUE_ID_W-1:0]     req_queue_id,
   input  logic [spmq_pkg::PAYLOAD_W-1:0]      req_payload_in,
   input  logic [spmq_pkg::SIZE_W-1:0]         req_size_in,
   input  logic                                csr_write_enable,
   input  logic [spmq_pkg::QUEUE_ID_W-1:0]     csr_index,
   input  logic [spmq_pkg::COUNT_W-1:0]        csr_write_data,
   output logic [spmq_pkg::STATUS_W-1:0]       rsp_status,
   output logic [spmq_pkg::PAYLOAD_W-1:0]      rsp_payload_out,
   output logic [spmq_pkg::SIZE_W-1:0]         rsp_size_out,
   output logic [spmq_pkg::COUNT_W-1:0]        rsp_queue_count,
   output logic [spmq_pkg::COUNT_W-1:0]        rsp_queue_peak,
   output logic [spmq_pkg::COUNT_W-1:0]        rsp_free_count
);

   localparam int SLOT_W = $clog2(POOL_SIZE);
   localparam int LINK_W = $clog2(POOL_SIZE + 1);
   localparam int CNT_W  = spmq_pkg::COUNT_W;
   localparam int FREE_OUT_W = (LINK_W > CNT_W) ? LINK_W : CNT_W;
   localparam int QID_W  = spmq_pkg::QUEUE_ID_W;
   localparam int NQ     = spmq_pkg::MAX_QUEUES;

   logic [LINK_W-1:0]              link_mem    [POOL_SIZE];
   logic [spmq_pkg::PAYLOAD_W-1:0] payload_mem [POOL_SIZE];
   logic [spmq_pkg::SIZE_W-1:0]    size_mem    [POOL_SIZE];

   logic [CNT_W-1:0]  limit_ff         [NQ];
   logic [SLOT_W-1:0] queue_head_ff    [NQ];
   logic [SLOT_W-1:0] queue_tail_ff    [NQ];
   logic [CNT_W-1:0]  queue_entries_ff [NQ];
   logic [CNT_W-1:0]  queue_peak_ff    [NQ];

   logic [LINK_W-1:0] free_head_ff;
   logic [LINK_W-1:0] free_head_in;
   logic [LINK_W-1:0] free_slots_ff;
   logic [LINK_W-1:0] free_slots_in;
   logic [LINK_W-1:0] fill_ff;
   logic [LINK_W-1:0] fill_in;

   logic                           cap_op_ff;
   logic [QID_W-1:0]               cap_qid_ff;
   logic                           cap_qok_ff;
   logic [spmq_pkg::PAYLOAD_W-1:0] cap_payload_ff;
   logic [spmq_pkg::SIZE_W-1:0]    cap_size_ff;
   logic [SLOT_W-1:0]              cap_head_ff;
   logic [SLOT_W-1:0]              cap_tail_ff;
   logic [CNT_W-1:0]               cap_entries_ff;
   logic [CNT_W-1:0]               cap_peak_ff;
   logic [CNT_W-1:0]               cap_limit_ff;
   logic [LINK_W-1:0]              rd_link_ff;
   logic [spmq_pkg::PAYLOAD_W-1:0] rd_payload_ff;
   logic [spmq_pkg::SIZE_W-1:0]    rd_size_ff;

   logic [spmq_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [spmq_pkg::STATUS_W-1:0]  rsp_status_in;
   logic [spmq_pkg::PAYLOAD_W-1:0] rsp_payload_ff;
   logic [spmq_pkg::SIZE_W-1:0]    rsp_size_ff;
   logic [CNT_W-1:0]               rsp_count_ff;
   logic [CNT_W-1:0]               rsp_peak_ff;
   logic [CNT_W-1:0]               rsp_free_ff;

   logic              req_qok;
   logic [SLOT_W-1:0] rd_addr;

   logic [SLOT_W-1:0]     slot;
   logic                  untouched;
   logic [LINK_W-1:0]     next_link;
   logic                  get_ok;
   logic                  put_ok;
   logic                  at_limit;
   logic [CNT_W-1:0]      entries_new;
   logic [CNT_W-1:0]      peak_new;
   logic [SLOT_W-1:0]     queue_head_in;
   logic [SLOT_W-1:0]     queue_tail_in;
   logic                  link_we;
   logic [SLOT_W-1:0]     link_addr;
   logic [LINK_W-1:0]     link_data;
   logic                  slot_we;
   logic [FREE_OUT_W-1:0] free_wide;

   assign req_qok = ({1'b0, req_queue_id} < (QID_W + 1)'(NUM_QUEUES));
   assign rd_addr = (req_operation == spmq_pkg::OP_GET) ? queue_head_ff[req_queue_id]
                                                        : free_head_ff[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cap_op_ff      <= req_operation;
         cap_qid_ff     <= req_queue_id;
         cap_qok_ff     <= req_qok;
         cap_payload_ff <= req_payload_in;
         cap_size_ff    <= req_size_in;
         cap_head_ff    <= queue_head_ff[req_queue_id];
         cap_tail_ff    <= queue_tail_ff[req_queue_id];
         cap_entries_ff <= queue_entries_ff[req_queue_id];
         cap_peak_ff    <= queue_peak_ff[req_queue_id];
         cap_limit_ff   <= limit_ff[req_queue_id];
         rd_link_ff     <= link_mem[rd_addr];
         rd_payload_ff  <= payload_mem[rd_addr];
         rd_size_ff     <= size_mem[rd_addr];
      end
   end

   // slots at or above the fill mark were never written and still link to the next slot
   assign slot      = (cap_op_ff == spmq_pkg::OP_GET) ? cap_head_ff : free_head_ff[SLOT_W-1:0];
   assign untouched = (LINK_W'(slot) >= fill_ff);
   assign next_link = untouched ? (LINK_W'(slot) + LINK_W'(1)) : rd_link_ff;

   assign at_limit = (cap_entries_ff >= cap_limit_ff);
   assign get_ok   = cap_qok_ff && (cap_op_ff == spmq_pkg::OP_GET) && (cap_entries_ff != '0);
   assign put_ok   = cap_qok_ff && (cap_op_ff == spmq_pkg::OP_PUT) && !at_limit
                     && (free_slots_ff != '0);

   always_comb begin
      priority if (get_ok) begin
         entries_new = cap_entries_ff - CNT_W'(1);
      end else if (put_ok) begin
         entries_new = cap_entries_ff + CNT_W'(1);
      end else begin
         entries_new = cap_entries_ff;
      end
   end

   assign peak_new = (put_ok && (entries_new > cap_peak_ff)) ? entries_new : cap_peak_ff;

   always_comb begin
      queue_head_in = cap_head_ff;
      queue_tail_in = cap_tail_ff;
      free_head_in  = free_head_ff;
      free_slots_in = free_slots_ff;
      fill_in       = fill_ff;
      if (get_ok) begin
         if (entries_new == '0) begin
            queue_head_in = '0;
            queue_tail_in = '0;
         end else begin
            queue_head_in = next_link[SLOT_W-1:0];
         end
         free_head_in  = LINK_W'(slot);
         free_slots_in = free_slots_ff + LINK_W'(1);
      end else if (put_ok) begin
         if (cap_entries_ff == '0) begin
            queue_head_in = slot;
         end
         queue_tail_in = slot;
         free_head_in  = next_link;
         free_slots_in = free_slots_ff - LINK_W'(1);
         if (untouched) begin
            fill_in = fill_ff + LINK_W'(1);
         end
      end
   end

   always_comb begin
      priority if (!cap_qok_ff) begin
         rsp_status_in = (cap_op_ff == spmq_pkg::OP_GET) ? spmq_pkg::STATUS_EMPTY
                                                         : spmq_pkg::STATUS_FULL;
      end else if (cap_op_ff == spmq_pkg::OP_GET) begin
         rsp_status_in = get_ok ? spmq_pkg::STATUS_OK : spmq_pkg::STATUS_EMPTY;
      end else if (at_limit) begin
         rsp_status_in = spmq_pkg::STATUS_FULL;
      end else if (!put_ok) begin
         rsp_status_in = spmq_pkg::STATUS_EXHAUSTED;
      end else begin
         rsp_status_in = spmq_pkg::STATUS_OK;
      end
   end

   // a get pushes its slot on the free list; a put links the new slot behind the tail
   assign link_we   = cmd.commit && (get_ok || (put_ok && (cap_entries_ff != '0)));
   assign link_addr = get_ok ? slot : cap_tail_ff;
   assign link_data = get_ok ? free_head_ff : LINK_W'(slot);
   assign slot_we   = cmd.commit && put_ok;

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_addr] <= link_data;
      end
      if (slot_we) begin
         payload_mem[slot] <= cap_payload_ff;
         size_mem[slot]    <= cap_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            limit_ff[i]         <= spmq_pkg::LIMIT_RESET;
            queue_head_ff[i]    <= '0;
            queue_tail_ff[i]    <= '0;
            queue_entries_ff[i] <= '0;
            queue_peak_ff[i]    <= '0;
         end
         free_head_ff  <= '0;
         free_slots_ff <= LINK_W'(POOL_SIZE);
         fill_ff       <= '0;
      end else begin
         if (csr_write_enable) begin
            limit_ff[csr_index] <= csr_write_data;
         end
         if (cmd.commit && (get_ok || put_ok)) begin
            queue_head_ff[cap_qid_ff]    <= queue_head_in;
            queue_tail_ff[cap_qid_ff]    <= queue_tail_in;
            queue_entries_ff[cap_qid_ff] <= entries_new;
            queue_peak_ff[cap_qid_ff]    <= peak_new;
            free_head_ff                 <= free_head_in;
            free_slots_ff                <= free_slots_in;
            fill_ff                      <= fill_in;
         end
      end
   end

   assign free_wide = FREE_OUT_W'(free_slots_in);

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff  <= rsp_status_in;
         rsp_payload_ff <= get_ok ? rd_payload_ff : '0;
         rsp_size_ff    <= get_ok ? rd_size_ff : '0;
         rsp_count_ff   <= cap_qok_ff ? entries_new : '0;
         rsp_peak_ff    <= cap_qok_ff ? peak_new : '0;
         rsp_free_ff    <= free_wide[CNT_W-1:0];
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_payload_out = rsp_payload_ff;
   assign rsp_size_out    = rsp_size_ff;
   assign rsp_queue_count = rsp_count_ff;
   assign rsp_queue_peak  = rsp_peak_ff;
   assign rsp_free_count  = rsp_free_ff;

endmodule

// ===== rtl/shared_pool_message_queues.sv =====
// Up to four FIFO message queues share one pool of POOL_SIZE slots kept on a linked free
// list. Each request word puts or gets one message and yields exactly one response word.
// A word has an accept cycle that reads the slot memories (link, payload, size, all with
// registered reads), then a commit, held while an untaken response waits, that updates
// the list pointers, writes the single link port and loads the response register. The next
// word is taken while a response still waits. Unwritten slots past a fill mark read as
// linked to the next slot, so the pool is usable right after reset with no clearing pass.
module shared_pool_message_queues #(
   parameter int POOL_SIZE  = 64,
   parameter int NUM_QUEUES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [spmq_pkg::QUEUE_ID_W-1:0] req_queue_id,
   input  logic [spmq_pkg::PAYLOAD_W-1:0]  req_payload_in,
   input  logic [spmq_pkg::SIZE_W-1:0]     req_size_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [spmq_pkg::STATUS_W-1:0]   rsp_status,
   output logic [spmq_pkg::PAYLOAD_W-1:0]  rsp_payload_out,
   output logic [spmq_pkg::SIZE_W-1:0]     rsp_size_out,
   output logic [spmq_pkg::COUNT_W-1:0]    rsp_queue_count,
   output logic [spmq_pkg::COUNT_W-1:0]    rsp_queue_peak,
   output logic [spmq_pkg::COUNT_W-1:0]    rsp_free_count,
   input  logic                            csr_write_enable,
   input  logic [spmq_pkg::QUEUE_ID_W-1:0] csr_index,
   input  logic [spmq_pkg::COUNT_W-1:0]    csr_write_data
);

   spmq_pkg::cmd_type cmd;

   spmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spmq_datapath #(
      .POOL_SIZE  (POOL_SIZE),
      .NUM_QUEUES (NUM_QUEUES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_operation    (req_operation),
      .req_queue_id     (req_queue_id),
      .req_payload_in   (req_payload_in),
      .req_size_in      (req_size_in),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_status       (rsp_status),
      .rsp_payload_out  (rsp_payload_out),
      .rsp_size_out     (rsp_size_out),
      .rsp_queue_count  (rsp_queue_count),
      .rsp_queue_peak   (rsp_queue_peak),
      .rsp_free_count   (rsp_free_count)
   );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

localparam int POOL_SLOTS = 64;
localparam int QUEUE_ID_W = spmq_pkg::QUEUE_ID_W;
localparam int PAYLOAD_W  = spmq_pkg::PAYLOAD_W;
localparam int SIZE_W     = spmq_pkg::SIZE_W;
localparam int STATUS_W   = spmq_pkg::STATUS_W;
localparam int COUNT_W    = spmq_pkg::COUNT_W;

typedef struct {
   logic [PAYLOAD_W-1:0] payload;
   logic [SIZE_W-1:0]    msg_size;
} stored_message_type;

typedef struct {
   logic [STATUS_W-1:0]  status;
   logic [PAYLOAD_W-1:0] payload;
   logic [SIZE_W-1:0]    msg_size;
   logic [COUNT_W-1:0]   count;
   logic [COUNT_W-1:0]   peak;
   logic [COUNT_W-1:0]   free_count;
} queue_reply_type;

class message_pool_model;
   stored_message_type held[spmq_pkg::MAX_QUEUES][$];
   int unsigned        limit[spmq_pkg::MAX_QUEUES];
   int unsigned        peak_depth[spmq_pkg::MAX_QUEUES];
   int unsigned        free_slots;
   queue_reply_type    pending_replies[$];
   int                 failures;

   function new();
      for (int i = 0; i < spmq_pkg::MAX_QUEUES; i++) begin
         limit[i] = spmq_pkg::LIMIT_RESET;
         peak_depth[i] = 0;
      end
      free_slots = POOL_SLOTS;
      failures = 0;
   endfunction

   function void set_limit(int idx, int unsigned value);
      limit[idx] = value;
   endfunction

   function int pending();
      return pending_replies.size();
   endfunction

   function void accept_request(logic op, logic [QUEUE_ID_W-1:0] q,
                                logic [PAYLOAD_W-1:0] pay, logic [SIZE_W-1:0] sz);
      queue_reply_type    r;
      stored_message_type m;
      r.status = spmq_pkg::STATUS_OK;
      r.payload = '0;
      r.msg_size = '0;
      if (op == spmq_pkg::OP_GET) begin
         if (held[q].size() == 0) begin
            r.status = spmq_pkg::STATUS_EMPTY;
         end else begin
            m = held[q].pop_front();
            r.payload = m.payload;
            r.msg_size = m.msg_size;
            free_slots++;
         end
      end else begin
         if (held[q].size() >= limit[q]) begin
            r.status = spmq_pkg::STATUS_FULL;
         end else if (free_slots == 0) begin
            r.status = spmq_pkg::STATUS_EXHAUSTED;
         end else begin
            m.payload = pay;
            m.msg_size = sz;
            held[q].push_back(m);
            free_slots--;
            if (held[q].size() > peak_depth[q]) peak_depth[q] = held[q].size();
         end
      end
      r.count = COUNT_W'(held[q].size());
      r.peak = COUNT_W'(peak_depth[q]);
      r.free_count = COUNT_W'(free_slots);
      pending_replies.push_back(r);
   endfunction

   function void compare(string name, logic [PAYLOAD_W-1:0] want, logic [PAYLOAD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   function void match_reply(queue_reply_type got);
      queue_reply_type want;
      if (pending_replies.size() == 0) begin
         $display("%0t: response word with nothing expected, status %0h payload %0h",
                  $time, got.status, got.payload);
         failures++;
         return;
      end
      want = pending_replies.pop_front();
      compare("status", PAYLOAD_W'(want.status), PAYLOAD_W'(got.status));
      compare("payload_out", want.payload, got.payload);
      compare("size_out", PAYLOAD_W'(want.msg_size), PAYLOAD_W'(got.msg_size));
      compare("queue_count", PAYLOAD_W'(want.count), PAYLOAD_W'(got.count));
      compare("queue_peak", PAYLOAD_W'(want.peak), PAYLOAD_W'(got.peak));
      compare("free_count", PAYLOAD_W'(want.free_count), PAYLOAD_W'(got.free_count));
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_WORDS = 190;
   localparam logic [QUEUE_ID_W-1:0] LIMIT_REG_BASE = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = spmq_pkg::OP_PUT;
   logic [QUEUE_ID_W-1:0] req_queue_id = '0;
   logic [PAYLOAD_W-1:0]  req_payload_in = '0;
   logic [SIZE_W-1:0]     req_size_in = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [PAYLOAD_W-1:0]  rsp_payload_out;
   logic [SIZE_W-1:0]     rsp_size_out;
   logic [COUNT_W-1:0]    rsp_queue_count;
   logic [COUNT_W-1:0]    rsp_queue_peak;
   logic [COUNT_W-1:0]    rsp_free_count;
   logic                  csr_write_enable = 1'b0;
   logic [QUEUE_ID_W-1:0] csr_index = '0;
   logic [COUNT_W-1:0]    csr_write_data = '0;

   bit                    calm = 1'b0;
   int unsigned           cycle_count = 0;
   message_pool_model     pool = new();

   shared_pool_message_queues #(
      .POOL_SIZE  (POOL_SLOTS),
      .NUM_QUEUES (spmq_pkg::MAX_QUEUES)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_queue_id     (req_queue_id),
      .req_payload_in   (req_payload_in),
      .req_size_in      (req_size_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_payload_out  (rsp_payload_out),
      .rsp_size_out     (rsp_size_out),
      .rsp_queue_count  (rsp_queue_count),
      .rsp_queue_peak   (rsp_queue_peak),
      .rsp_free_count   (rsp_free_count),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      queue_reply_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pool.accept_request(req_operation, req_queue_id, req_payload_in, req_size_in);
         end
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.payload = rsp_payload_out;
            got.msg_size = rsp_size_out;
            got.count = rsp_queue_count;
            got.peak = rsp_queue_peak;
            got.free_count = rsp_free_count;
            pool.match_reply(got);
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 13);
   end

   task automatic send_word(logic op, logic [QUEUE_ID_W-1:0] q,
                            logic [PAYLOAD_W-1:0] pay, logic [SIZE_W-1:0] sz);
      while (!calm && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_queue_id <= q;
      req_payload_in <= pay;
      req_size_in <= sz;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pool.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_limits(int unsigned l0, int unsigned l1, int unsigned l2,
                               int unsigned l3);
      int unsigned lims[spmq_pkg::MAX_QUEUES];
      lims = '{l0, l1, l2, l3};
      wait_idle();
      for (int i = 0; i < spmq_pkg::MAX_QUEUES; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= LIMIT_REG_BASE + QUEUE_ID_W'(i);
         csr_write_data <= COUNT_W'(lims[i]);
         pool.set_limit(i, lims[i]);
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(int unsigned l0, int unsigned l1, int unsigned l2,
                            int unsigned l3, int unsigned put_pct, bit quiet);
      logic op;
      write_limits(l0, l1, l2, l3);
      calm = quiet;
      for (int n = 0; n < PHASE_WORDS; n++) begin
         op = ($urandom_range(0, 99) < put_pct) ? spmq_pkg::OP_PUT : spmq_pkg::OP_GET;
         send_word(op, QUEUE_ID_W'($urandom_range(0, spmq_pkg::MAX_QUEUES - 1)), $urandom(),
                   SIZE_W'($urandom_range(0, 65535)));
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_word(spmq_pkg::OP_GET, 2'd0, '0, '0);
      send_word(spmq_pkg::OP_PUT, 2'd0, 32'h0000_0000, 16'h0000);
      send_word(spmq_pkg::OP_PUT, 2'd1, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(spmq_pkg::OP_PUT, 2'd2, 32'hAAAA_AAAA, 16'hAAAA);
      send_word(spmq_pkg::OP_PUT, 2'd3, 32'h5555_5555, 16'h5555);
      for (int q = 0; q < spmq_pkg::MAX_QUEUES; q++) begin
         send_word(spmq_pkg::OP_GET, QUEUE_ID_W'(q), 32'hFFFF_FFFF, 16'hFFFF);
      end
      send_word(spmq_pkg::OP_GET, 2'd3, '0, '0);

      write_limits(0, 64, 1, 64);
      send_word(spmq_pkg::OP_PUT, 2'd0, 32'h1234_5678, 16'h00FF);
      send_word(spmq_pkg::OP_PUT, 2'd2, 32'h8765_4321, 16'hFF00);
      send_word(spmq_pkg::OP_PUT, 2'd2, 32'hDEAD_BEEF, 16'h0001);
      send_word(spmq_pkg::OP_GET, 2'd2, '0, '0);
      send_word(spmq_pkg::OP_GET, 2'd0, '0, '0);

      run_phase(64, 64, 64, 64, 85, 1'b0);
      run_phase(0, 64, 1, 7, 60, 1'b0);
      run_phase(64, 64, 64, 64, 15, 1'b0);
      run_phase(16, 16, 16, 16, 80, 1'b1);
      run_phase(64, 0, 64, 0, 50, 1'b0);
      run_phase($urandom_range(0, 64), $urandom_range(0, 64), $urandom_range(0, 64),
                $urandom_range(0, 64), 70, 1'b0);
      run_phase(64, 64, 64, 64, 10, 1'b0);
      run_phase(2, 3, 1, 64, 55, 1'b0);
      run_phase($urandom_range(0, 64), $urandom_range(0, 64), $urandom_range(0, 64),
                $urandom_range(0, 64), 50, 1'b0);
      run_phase(64, 64, 64, 64, 90, 1'b0);

      wait_idle();
      repeat (8) @(negedge clock);
      if (pool.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
